// ===== rtl/toei_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the tile offset / extent / index unit.
// No dependencies; used by every module of the block.
package toei_pkg;

	localparam int NUM_DIMS  = 3;
	localparam int EXT_W     = 16;
	localparam int WGT_W     = 2 * EXT_W;
	localparam int ID_W      = 48;
	localparam int TOTAL_W   = 49;
	localparam int DIMS_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = $clog2(EXT_W + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ORDER   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE_2 = 3'd7;

	// Per-dimension settings seen by one cell
	typedef struct packed {
		logic             act;
		logic [EXT_W-1:0] cnt;
		logic [EXT_W-1:0] ts;
		logic [EXT_W-1:0] bsz;
		logic [WGT_W-1:0] wgt;
	} dim_cfg_t;

	// Item travelling down the row of cells
	typedef struct packed {
		logic [NUM_DIMS-1:0][EXT_W-1:0] coord;
		logic [NUM_DIMS-1:0][EXT_W-1:0] off;
		logic [NUM_DIMS-1:0][EXT_W-1:0] span;
		logic [ID_W-1:0]                acc;
		logic [ID_W-1:0]                prod;
		logic                           err;
	} item_t;

endpackage

// ===== rtl/toei_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for one dimension: tile count (ceiling) and border tile size.
// Depends on toei_pkg for the extent width.
module toei_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [toei_pkg::EXT_W-1:0] dividend,
	input  logic [toei_pkg::EXT_W-1:0] divisor,
	output logic                      done,
	output logic [toei_pkg::EXT_W-1:0] tiles,
	output logic [toei_pkg::EXT_W-1:0] border
);

	logic                        busy_q;
	logic                        done_q;
	logic [toei_pkg::STEP_W-1:0] step_q;
	logic [toei_pkg::EXT_W-1:0]  quo_q;
	logic [toei_pkg::EXT_W-1:0]  rem_q;
	logic [toei_pkg::EXT_W-1:0]  dvs_q;

	logic [toei_pkg::EXT_W:0]    shifted;
	logic [toei_pkg::EXT_W:0]    diff;
	logic                        ge;
	logic [toei_pkg::EXT_W-1:0]  rem_next;
	logic                        rem_nz;

	assign shifted  = {rem_q, quo_q[toei_pkg::EXT_W-1]};
	assign ge       = shifted >= {1'b0, dvs_q};
	assign diff     = shifted - {1'b0, dvs_q};
	assign rem_next = ge ? diff[toei_pkg::EXT_W-1:0] : shifted[toei_pkg::EXT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= toei_pkg::STEP_W'(toei_pkg::EXT_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == toei_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[toei_pkg::EXT_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rem_nz = rem_q != '0;
	assign done   = done_q;
	assign tiles  = (dvs_q == '0) ? '0 : quo_q + toei_pkg::EXT_W'(rem_nz);
	assign border = (dvs_q == '0) ? '0 : (rem_nz ? rem_q : dvs_q);

endmodule

// ===== rtl/toei_cell.sv =====
`timescale 1ns / 1ps
// One cell of the dimension chain: range check, offset, span and id term for one dimension.
// Depends on toei_pkg for item_t and dim_cfg_t.
module toei_cell #(
	parameter int DIM = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_in,
	input  toei_pkg::item_t    item_in,
	input  toei_pkg::dim_cfg_t cfg,
	output logic               valid_out,
	output toei_pkg::item_t    item_out
);

	logic                         valid_q;
	toei_pkg::item_t              item_q;
	toei_pkg::item_t              item_next;
	logic [toei_pkg::EXT_W-1:0]   c;
	logic [2*toei_pkg::EXT_W-1:0] off_full;
	logic [toei_pkg::ID_W-1:0]    prod_full;
	logic                         err_d;
	logic                         last;

	assign c         = item_in.coord[DIM];
	assign err_d     = cfg.act && (c >= cfg.cnt);
	assign last      = c == (cfg.cnt - 1'b1);
	assign off_full  = c * cfg.ts;
	assign prod_full = c * cfg.wgt;

	always_comb begin
		item_next = item_in;
		// fold the previous cell's id term while this one forms its own
		item_next.acc = item_in.acc + item_in.prod;
		item_next.err = item_in.err | err_d;
		if (cfg.act) begin
			item_next.off[DIM]  = off_full[toei_pkg::EXT_W-1:0];
			item_next.span[DIM] = last ? cfg.bsz : cfg.ts;
			item_next.prod      = prod_full;
		end else begin
			item_next.off[DIM]  = '0;
			item_next.span[DIM] = toei_pkg::EXT_W'(1);
			item_next.prod      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= item_next;
		end
	end

	assign valid_out = valid_q;
	assign item_out  = item_q;

endmodule

// ===== rtl/tile_offset_extent_index_unit.sv =====
`timescale 1ns / 1ps
// Top level of the tile offset / extent / index unit: configuration, derivation and cell chain.
// Depends on toei_pkg, toei_div and toei_cell.

// Takes one coordinate set per cycle unless in_stall or out_stall holds the flow, and
// returns one result per set through one pipeline cell per dimension, then the output
// register. Stages advance independently, so the input keeps flowing into empty stages
// while a result waits at the output. After every configuration write the input stalls
// while three restoring dividers (one quotient bit a cycle) rebuild tile counts and
// border sizes, then two multiply steps rebuild the id weights and the total tile
// count. Write configuration only with no transfer in flight.
module tile_offset_extent_index_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [toei_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [toei_pkg::EXT_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [toei_pkg::EXT_W-1:0]      coord_a,
	input  logic [toei_pkg::EXT_W-1:0]      coord_b,
	input  logic [toei_pkg::EXT_W-1:0]      coord_c,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [toei_pkg::EXT_W-1:0]      offset_0,
	output logic [toei_pkg::EXT_W-1:0]      offset_1,
	output logic [toei_pkg::EXT_W-1:0]      offset_2,
	output logic [toei_pkg::EXT_W-1:0]      span_0,
	output logic [toei_pkg::EXT_W-1:0]      span_1,
	output logic [toei_pkg::EXT_W-1:0]      span_2,
	output logic [toei_pkg::ID_W-1:0]       tile_number,
	output logic [toei_pkg::TOTAL_W-1:0]    tile_total,
	output logic                            range_error
);

	localparam int ND = toei_pkg::NUM_DIMS;
	localparam int EW = toei_pkg::EXT_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_WGT  = 3'd3;
	localparam logic [2:0] ST_TOT  = 3'd4;

	logic                            cfg_wr;
	logic                            row_order_q;
	logic [toei_pkg::DIMS_W-1:0]     dims_q;
	logic [ND-1:0][EW-1:0]           extent_q;
	logic [ND-1:0][EW-1:0]           tsize_q;
	logic [ND-1:0][EW-1:0]           tiles_q;
	logic [ND-1:0][EW-1:0]           border_q;
	logic [ND-1:0][toei_pkg::WGT_W-1:0] wgt_q;
	logic [toei_pkg::TOTAL_W-1:0]    total_q;
	logic [2:0]                      state_q;

	logic                            busy;
	logic                            div_start;
	logic [ND-1:0]                   div_done;
	logic [ND-1:0][EW-1:0]           div_tiles;
	logic [ND-1:0][EW-1:0]           div_border;
	logic [toei_pkg::DIMS_W-1:0]     n_eff;
	logic [ND-1:0]                   act;
	logic [ND-1:0][EW-1:0]           ecnt;
	logic [toei_pkg::WGT_W-1:0]      wgt_prod;
	logic [toei_pkg::ID_W-1:0]       tot_prod;

	toei_pkg::item_t                 item_in0;
	toei_pkg::item_t                 cell_item [ND];
	toei_pkg::dim_cfg_t              dim_cfg [ND];
	logic [ND-1:0]                   cell_valid;
	logic [ND-1:0]                   cell_en;
	logic                            out_en;
	logic                            accept;

	logic                            valid_s4;
	logic [ND-1:0][EW-1:0]           off_s4;
	logic [ND-1:0][EW-1:0]           span_s4;
	logic [toei_pkg::ID_W-1:0]       number_s4;
	logic [toei_pkg::TOTAL_W-1:0]    total_s4;
	logic                            err_s4;
	toei_pkg::item_t                 last_item;
	logic [toei_pkg::ID_W-1:0]       number_sum;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_order_q <= 1'b0;
			dims_q      <= toei_pkg::DIMS_W'(3);
			extent_q    <= {ND{EW'(1)}};
			tsize_q     <= {ND{EW'(1)}};
		end else if (cfg_wr) begin
			unique case (cfg_index)
				toei_pkg::REG_ROW_ORDER:   row_order_q <= cfg_data[0];
				toei_pkg::REG_DIMS_IN_USE: dims_q      <= cfg_data[toei_pkg::DIMS_W-1:0];
				toei_pkg::REG_EXTENT_0:    extent_q[0] <= cfg_data;
				toei_pkg::REG_EXTENT_1:    extent_q[1] <= cfg_data;
				toei_pkg::REG_EXTENT_2:    extent_q[2] <= cfg_data;
				toei_pkg::REG_TILE_SIZE_0: tsize_q[0]  <= cfg_data;
				toei_pkg::REG_TILE_SIZE_1: tsize_q[1]  <= cfg_data;
				toei_pkg::REG_TILE_SIZE_2: tsize_q[2]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- derivation ----------------
	assign n_eff = (dims_q == '0) ? toei_pkg::DIMS_W'(1) : dims_q;

	always_comb begin
		for (int d = 0; d < ND; d++) begin
			act[d]  = toei_pkg::DIMS_W'(d) < n_eff;
			ecnt[d] = act[d] ? tiles_q[d] : EW'(1);
		end
	end

	assign wgt_prod  = ecnt[1] * ecnt[2];
	assign tot_prod  = wgt_q[0] * ecnt[0];
	assign div_start = state_q == ST_LOAD;
	assign busy      = state_q != ST_IDLE;

	for (genvar d = 0; d < ND; d++) begin : g_div
		toei_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (extent_q[d]),
			.divisor  (tsize_q[d]),
			.done     (div_done[d]),
			.tiles    (div_tiles[d]),
			.border   (div_border[d])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tiles_q  <= {ND{EW'(1)}};
			border_q <= {ND{EW'(1)}};
			wgt_q    <= {ND{toei_pkg::WGT_W'(1)}};
			total_q  <= toei_pkg::TOTAL_W'(1);
		end else if (cfg_wr) begin
			// any write restarts the derivation
			state_q <= ST_LOAD;
		end else begin
			unique case (state_q)
				ST_IDLE: state_q <= ST_IDLE;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (&div_done) begin
						tiles_q  <= div_tiles;
						border_q <= div_border;
						state_q  <= ST_WGT;
					end
				end
				ST_WGT: begin
					wgt_q[0] <= wgt_prod;
					wgt_q[1] <= toei_pkg::WGT_W'(ecnt[2]);
					wgt_q[2] <= toei_pkg::WGT_W'(1);
					state_q  <= ST_TOT;
				end
				ST_TOT: begin
					total_q <= toei_pkg::TOTAL_W'(tot_prod);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- cell chain ----------------
	assign out_en   = !valid_s4 || !out_stall;
	assign in_stall = busy || !cell_en[0];
	assign accept   = in_valid && !in_stall;

	always_comb begin
		item_in0      = '0;
		item_in0.coord[0] = coord_a;
		item_in0.coord[1] = coord_b;
		item_in0.coord[2] = coord_c;
		// row order: reverse the coordinates over the dimensions in use
		if (row_order_q) begin
			unique case (n_eff)
				toei_pkg::DIMS_W'(2): begin
					item_in0.coord[0] = coord_b;
					item_in0.coord[1] = coord_a;
				end
				toei_pkg::DIMS_W'(3): begin
					item_in0.coord[0] = coord_c;
					item_in0.coord[2] = coord_a;
				end
				default: ;
			endcase
		end
	end

	for (genvar d = 0; d < ND; d++) begin : g_cell
		assign dim_cfg[d] = '{act: act[d], cnt: tiles_q[d], ts: tsize_q[d],
			bsz: border_q[d], wgt: wgt_q[d]};

		if (d == ND - 1) begin : g_en_last
			assign cell_en[d] = !cell_valid[d] || out_en;
		end else begin : g_en_mid
			assign cell_en[d] = !cell_valid[d] || cell_en[d+1];
		end

		if (d == 0) begin : g_first
			toei_cell #(.DIM(d)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (cell_en[d]),
				.valid_in  (accept),
				.item_in   (item_in0),
				.cfg       (dim_cfg[d]),
				.valid_out (cell_valid[d]),
				.item_out  (cell_item[d])
			);
		end else begin : g_next
			toei_cell #(.DIM(d)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (cell_en[d]),
				.valid_in  (cell_valid[d-1]),
				.item_in   (cell_item[d-1]),
				.cfg       (dim_cfg[d]),
				.valid_out (cell_valid[d]),
				.item_out  (cell_item[d])
			);
		end
	end

	// ---------------- output register ----------------
	assign last_item  = cell_item[ND-1];
	assign number_sum = last_item.acc + last_item.prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (out_en) begin
			valid_s4 <= cell_valid[ND-1];
		end
	end

	// a range error clears every other field
	always_ff @(posedge clk) begin
		if (out_en) begin
			err_s4    <= last_item.err;
			off_s4    <= last_item.err ? '0 : last_item.off;
			span_s4   <= last_item.err ? '0 : last_item.span;
			number_s4 <= last_item.err ? '0 : number_sum;
			total_s4  <= last_item.err ? '0 : total_q;
		end
	end

	assign out_valid   = valid_s4;
	assign offset_0    = off_s4[0];
	assign offset_1    = off_s4[1];
	assign offset_2    = off_s4[2];
	assign span_0      = span_s4[0];
	assign span_1      = span_s4[1];
	assign span_2      = span_s4[2];
	assign tile_number = number_s4;
	assign tile_total  = total_s4;
	assign range_error = err_s4;

	// ---------------- assertions ----------------
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("input transfer taken straight after a configuration write");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> (tile_number == '0) && (tile_total == '0))
		else $error("range error with non-zero id or total");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> tile_total != '0)
		else $error("zero tile total on an in-range result");

	a_id_below_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_error |-> {1'b0, tile_number} < tile_total)
		else $error("tile id not below tile total");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tile_offset_extent_index_unit: directed table, then random phases.
// Depends on toei_pkg and the RTL of the unit; the tile placement is predicted locally.
module tb_top;

	localparam int NUM_DIMS  = toei_pkg::NUM_DIMS;
	localparam int EXT_W     = toei_pkg::EXT_W;
	localparam int ID_W      = toei_pkg::ID_W;
	localparam int TOTAL_W   = toei_pkg::TOTAL_W;
	localparam int DIMS_W    = toei_pkg::DIMS_W;
	localparam int CFG_IDX_W = toei_pkg::CFG_IDX_W;

	localparam int LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 50;

	typedef struct packed {
		logic [NUM_DIMS-1:0][EXT_W-1:0] off;
		logic [NUM_DIMS-1:0][EXT_W-1:0] span;
		logic [ID_W-1:0]                id;
		logic [TOTAL_W-1:0]             total;
		logic                           err;
	} tile_res_t;

	typedef struct packed {
		logic                           ro;
		logic [DIMS_W-1:0]              dims;
		logic [NUM_DIMS-1:0][EXT_W-1:0] ext;
		logic [NUM_DIMS-1:0][EXT_W-1:0] ts;
	} cfg_set_t;

	typedef struct packed {
		logic [3:0]                     cfg_no;
		logic [NUM_DIMS-1:0][EXT_W-1:0] crd;
		logic                           typed;
		tile_res_t                      want;
	} dir_row_t;

	localparam tile_res_t RES_ERR = '{err: 1'b1, default: '0};
	localparam tile_res_t RES_ORIGIN = '{span: {3{16'd1}}, total: 49'd1, default: '0};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [EXT_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [EXT_W-1:0] coord_a, coord_b, coord_c;
	logic out_valid;
	logic out_stall;
	logic [EXT_W-1:0] offset_0, offset_1, offset_2;
	logic [EXT_W-1:0] span_0, span_1, span_2;
	logic [ID_W-1:0] tile_number;
	logic [TOTAL_W-1:0] tile_total;
	logic range_error;

	// predictor state
	logic             pr_ro;
	logic [DIMS_W-1:0] pr_dims;
	logic [EXT_W-1:0] pr_ext[NUM_DIMS];
	logic [EXT_W-1:0] pr_ts[NUM_DIMS];
	logic [EXT_W-1:0] pr_cnt[NUM_DIMS];
	logic [EXT_W-1:0] pr_border[NUM_DIMS];

	tile_res_t pending_places[$];
	bit calm;
	int n_fail;
	int n_results;
	int n_range_errs;
	int n_settings;

	tile_offset_extent_index_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.coord_a(coord_a), .coord_b(coord_b), .coord_c(coord_c),
		.out_valid(out_valid), .out_stall(out_stall),
		.offset_0(offset_0), .offset_1(offset_1), .offset_2(offset_2),
		.span_0(span_0), .span_1(span_1), .span_2(span_2),
		.tile_number(tile_number), .tile_total(tile_total), .range_error(range_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void rebuild_counts();
		logic [EXT_W-1:0] q, rm;
		for (int d = 0; d < NUM_DIMS; d++) begin
			if (pr_ts[d] == '0) begin
				pr_cnt[d] = '0;
				pr_border[d] = '0;
			end else begin
				q = pr_ext[d] / pr_ts[d];
				rm = pr_ext[d] % pr_ts[d];
				pr_border[d] = (rm == '0) ? pr_ts[d] : rm;
				pr_cnt[d] = (rm == '0) ? q : q + 16'd1;
			end
		end
	endfunction

	function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [EXT_W-1:0] data);
		case (idx)
			toei_pkg::REG_ROW_ORDER:   pr_ro = data[0];
			toei_pkg::REG_DIMS_IN_USE: pr_dims = data[DIMS_W-1:0];
			toei_pkg::REG_EXTENT_0:    pr_ext[0] = data;
			toei_pkg::REG_EXTENT_1:    pr_ext[1] = data;
			toei_pkg::REG_EXTENT_2:    pr_ext[2] = data;
			toei_pkg::REG_TILE_SIZE_0: pr_ts[0] = data;
			toei_pkg::REG_TILE_SIZE_1: pr_ts[1] = data;
			toei_pkg::REG_TILE_SIZE_2: pr_ts[2] = data;
			default: ;
		endcase
		rebuild_counts();
	endfunction

	function automatic tile_res_t place_tile(input logic [NUM_DIMS-1:0][EXT_W-1:0] crd);
		tile_res_t r;
		int n, src;
		logic [63:0] cv, cnt, ts;
		r = RES_ORIGIN;
		n = (pr_dims == '0) ? 1 : int'(pr_dims);
		for (int d = 0; d < n; d++) begin
			src = pr_ro ? (n - 1 - d) : d;
			cv = 64'(crd[src]);
			cnt = 64'(pr_cnt[d]);
			ts = 64'(pr_ts[d]);
			if (cv >= cnt) begin
				r.err = 1'b1;
			end else begin
				r.off[d] = 16'(cv * ts);
				r.span[d] = (cv == cnt - 1) ? pr_border[d] : pr_ts[d];
				r.id = 48'(64'(r.id) * cnt + cv);
				r.total = 49'(64'(r.total) * cnt);
			end
		end
		if (r.err)
			r = RES_ERR;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input int cfg_no, input int a, input int b, input int c,
			input bit typed, input tile_res_t want);
		dir_row_t row;
		row.cfg_no = 4'(cfg_no);
		row.crd = {16'(c), 16'(b), 16'(a)};
		row.typed = typed;
		row.want = want;
		return row;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EXT_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		note_reg_write(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_setting(input cfg_set_t s, input bit noisy);
		logic [EXT_W-1:0] hi;
		hi = noisy ? 16'($urandom) : '0;
		write_reg(toei_pkg::REG_ROW_ORDER, {hi[EXT_W-1:1], s.ro});
		write_reg(toei_pkg::REG_DIMS_IN_USE, {hi[EXT_W-1:DIMS_W], s.dims});
		for (int d = 0; d < NUM_DIMS; d++) begin
			write_reg(toei_pkg::REG_EXTENT_0 + CFG_IDX_W'(d), s.ext[d]);
			write_reg(toei_pkg::REG_TILE_SIZE_0 + CFG_IDX_W'(d), s.ts[d]);
		end
		n_settings++;
	endtask

	task automatic send_coords(input logic [NUM_DIMS-1:0][EXT_W-1:0] crd, input bit typed,
			input tile_res_t want);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		coord_a = crd[0];
		coord_b = crd[1];
		coord_c = crd[2];
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		pending_places.push_back(typed ? want : place_tile(crd));
	endtask

	// drop valid, drain the pipe, then idle before returning
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_places.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	initial begin : out_stall_gen
		int stall_left;
		out_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (calm) begin
				out_stall = 1'b0;
				stall_left = 0;
			end else if (stall_left != 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if ($urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(0, 14);
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		tile_res_t got, want;
		bit bad;
		if (arst_n && out_valid && !out_stall) begin
			got.off = {offset_2, offset_1, offset_0};
			got.span = {span_2, span_1, span_0};
			got.id = tile_number;
			got.total = tile_total;
			got.err = range_error;
			if (pending_places.size() == 0) begin
				$error("result transfer with no coordinate set pending");
				n_fail++;
			end else begin
				want = pending_places.pop_front();
				bad = 1'b0;
				for (int d = 0; d < NUM_DIMS; d++) begin
					if (got.off[d] !== want.off[d]) begin
						$error("offset_%0d: expected %0h, got %0h", d, want.off[d], got.off[d]);
						bad = 1'b1;
					end
					if (got.span[d] !== want.span[d]) begin
						$error("span_%0d: expected %0h, got %0h", d, want.span[d], got.span[d]);
						bad = 1'b1;
					end
				end
				if (got.id !== want.id) begin
					$error("tile_number: expected %0h, got %0h", want.id, got.id);
					bad = 1'b1;
				end
				if (got.total !== want.total) begin
					$error("tile_total: expected %0h, got %0h", want.total, got.total);
					bad = 1'b1;
				end
				if (got.err !== want.err) begin
					$error("range_error: expected %0b, got %0b", want.err, got.err);
					bad = 1'b1;
				end
				if (bad)
					n_fail++;
				n_results++;
				if (want.err)
					n_range_errs++;
			end
		end
	end

	// count cycles with no transfer on any channel
	initial begin : watchdog
		int stale;
		stale = 0;
		wait (arst_n === 1'b1);
		while (stale < LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				stale = 0;
			else
				stale++;
		end
		$display("watchdog: no transfer for %0d cycles", LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		dir_row_t drows[$];
		cfg_set_t dset[7];
		cfg_set_t rs;
		logic [NUM_DIMS-1:0][EXT_W-1:0] crd;
		int cur, n, kind, bad_dim, cnt, src, v;

		arst_n = 1'b0;
		in_valid = 1'b0;
		coord_a = '0;
		coord_b = '0;
		coord_c = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		n_fail = 0;
		n_results = 0;
		n_range_errs = 0;
		n_settings = 0;

		pr_ro = 1'b0;
		pr_dims = 2'd3;
		for (int d = 0; d < NUM_DIMS; d++) begin
			pr_ext[d] = 16'd1;
			pr_ts[d] = 16'd1;
		end
		rebuild_counts();

		// setting 0 is the reset state and is never written
		dset[0] = '0;
		dset[1] = '{ro: 1'b0, dims: 2'd3, ext: {3{16'd65535}}, ts: {3{16'd1}}};
		dset[2] = '{ro: 1'b1, dims: 2'd2, ext: {16'd7, 16'd65535, 16'd65535},
			ts: {16'd3, 16'd256, 16'd65535}};
		dset[3] = '{ro: 1'b0, dims: 2'd3, ext: {16'd0, 16'd10, 16'd10},
			ts: {16'd4, 16'd0, 16'd3}};
		dset[4] = '{ro: 1'b1, dims: 2'd0, ext: {16'd5, 16'd5, 16'd100},
			ts: {16'd5, 16'd5, 16'd7}};
		dset[5] = '{ro: 1'b0, dims: 2'd1, ext: {16'd9, 16'd0, 16'd1000},
			ts: {16'd9, 16'd0, 16'd64}};
		dset[6] = '{ro: 1'b1, dims: 2'd3, ext: {16'd50, 16'd300, 16'd65535},
			ts: {16'd50, 16'd17, 16'd1}};

		drows.push_back(mk_row(0, 0, 0, 0, 1, RES_ORIGIN));
		drows.push_back(mk_row(0, 65535, 65535, 65535, 1, RES_ERR));
		drows.push_back(mk_row(0, 0, 1, 0, 1, RES_ERR));
		drows.push_back(mk_row(1, 0, 0, 0, 1, '{span: {3{16'd1}},
			total: 49'h0_FFFD_0002_FFFF, default: '0}));
		drows.push_back(mk_row(1, 65534, 65534, 65534, 1, '{off: {3{16'd65534}},
			span: {3{16'd1}}, id: 48'hFFFD_0002_FFFE, total: 49'h0_FFFD_0002_FFFF,
			err: 1'b0}));
		drows.push_back(mk_row(1, 65535, 0, 0, 1, RES_ERR));
		drows.push_back(mk_row(1, 0, 0, 65535, 1, RES_ERR));
		// row order reversed over two dims; border tiles on both
		drows.push_back(mk_row(2, 255, 0, 65535, 0, '0));
		drows.push_back(mk_row(2, 0, 0, 0, 0, '0));
		drows.push_back(mk_row(2, 128, 0, 12345, 0, '0));
		drows.push_back(mk_row(2, 0, 1, 0, 1, RES_ERR));
		drows.push_back(mk_row(2, 256, 0, 0, 1, RES_ERR));
		// zero tile size and zero extent: nothing is in range
		drows.push_back(mk_row(3, 0, 0, 0, 1, RES_ERR));
		drows.push_back(mk_row(3, 3, 0, 0, 1, RES_ERR));
		// zero dims in use acts as one; unused coordinates are ignored
		drows.push_back(mk_row(4, 14, 65535, 65535, 0, '0));
		drows.push_back(mk_row(4, 0, 1, 2, 0, '0));
		drows.push_back(mk_row(4, 7, 0, 0, 0, '0));
		drows.push_back(mk_row(4, 15, 0, 0, 1, RES_ERR));
		drows.push_back(mk_row(5, 15, 9, 9, 0, '0));
		drows.push_back(mk_row(5, 3, 0, 0, 0, '0));
		drows.push_back(mk_row(5, 16, 0, 0, 1, RES_ERR));
		drows.push_back(mk_row(6, 0, 17, 65534, 0, '0));
		drows.push_back(mk_row(6, 0, 5, 1000, 0, '0));
		drows.push_back(mk_row(6, 1, 0, 0, 1, RES_ERR));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cur = 0;
		foreach (drows[i]) begin
			if (int'(drows[i].cfg_no) != cur) begin
				settle();
				cur = int'(drows[i].cfg_no);
				load_setting(dset[cur], 1'b0);
			end
			send_coords(drows[i].crd, drows[i].typed, drows[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			calm = (ph == PHASES - 1);
			rs.ro = 1'($urandom);
			rs.dims = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
			for (int d = 0; d < NUM_DIMS; d++) begin
				kind = $urandom_range(0, 19);
				if (kind < 10) begin
					rs.ext[d] = 16'($urandom_range(1, 300));
					rs.ts[d] = 16'($urandom_range(1, 64));
				end else if (kind < 14) begin
					rs.ext[d] = 16'($urandom_range(1, 65535));
					rs.ts[d] = 16'($urandom_range(1, 65535));
				end else if (kind < 17) begin
					rs.ext[d] = 16'($urandom_range(1, 65535));
					rs.ts[d] = 16'($urandom_range(1, 16));
				end else if (kind < 19) begin
					rs.ext[d] = $urandom_range(0, 1) ? 16'd65535 : 16'd1;
					rs.ts[d] = $urandom_range(0, 1) ? 16'd65535 : 16'd1;
				end else if ($urandom_range(0, 1) == 0) begin
					rs.ext[d] = '0;
					rs.ts[d] = 16'($urandom_range(1, 65535));
				end else begin
					rs.ext[d] = 16'($urandom);
					rs.ts[d] = '0;
				end
			end
			load_setting(rs, 1'b1);

			repeat (PHASE_ITEMS) begin
				for (int d = 0; d < NUM_DIMS; d++)
					crd[d] = 16'($urandom);
				n = (pr_dims == '0) ? 1 : int'(pr_dims);
				kind = $urandom_range(0, 9);
				bad_dim = $urandom_range(0, n - 1);
				// mostly in-range sets, some with one coordinate past the count, some raw
				if (kind < 8) begin
					for (int d = 0; d < n; d++) begin
						cnt = int'(pr_cnt[d]);
						if (cnt == 0)
							v = $urandom_range(0, 65535);
						else if (kind == 7 && d == bad_dim)
							v = (cnt == 65535) ? 65535 : $urandom_range(cnt, 65535);
						else begin
							case ($urandom_range(0, 3))
								0: v = cnt - 1;
								1: v = 0;
								default: v = $urandom_range(0, cnt - 1);
							endcase
						end
						src = pr_ro ? (n - 1 - d) : d;
						crd[src] = 16'(v);
					end
				end
				send_coords(crd, 1'b0, '0);
			end
		end

		settle();
		$display("checked %0d tile placements, %0d of them out of range", n_results,
			n_range_errs);
		$display("across %0d register settings, %0d mismatching results", n_settings, n_fail);
		if (n_fail == 0 && pending_places.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== tile_offset_extent_index_unit.f =====
rtl/toei_pkg.sv
rtl/toei_div.sv
rtl/toei_cell.sv
rtl/tile_offset_extent_index_unit.sv
tb/tb_top.sv
